// ----- rtl/evpsr_pkg.sv -----
// evpsr_pkg: shared types, constants and helpers of the ev pilot state relay controller
// used by every module of the block; depends on nothing

package evpsr_pkg;

  // field and storage widths
  localparam int ADC_BITS             = 12;
  localparam int CAPTURE_BITS         = 16;
  localparam int FILTER_FRACTION_BITS = 8;
  localparam int FILT_W               = ADC_BITS + FILTER_FRACTION_BITS;
  localparam int FREQ_W               = 20;
  localparam int DUTY_W               = 7;
  localparam int CUR_W                = 6;
  localparam int CFG_W                = 16;
  localparam int CFG_IDX_W            = 3;
  localparam int CMP_W                = FILT_W + 3;

  // one megahertz over the period in microseconds
  localparam int FREQ_NUM = 1000000;
  localparam int DUTY_MAX = 100;

  // period / 100 as multiply by reciprocal, exact for 16 bit periods
  localparam int P100_SHIFT = 23;
  localparam int P100_MUL   = (1 << P100_SHIFT) / 100 + 1;
  localparam int P100_MUL_W = 17;
  localparam int P100_W     = 10;

  // filter sum / 10 as multiply by reciprocal, exact below 2^24
  localparam int ACC_W      = FILT_W + 4;
  localparam int TEN_SHIFT  = 27;
  localparam int TEN_MUL    = (1 << TEN_SHIFT) / 10 + 1;
  localparam int TEN_MUL_W  = 24;

  // duty * 6 / 10, exact for duty up to 100
  localparam int CUR_MUL    = 205;
  localparam int CUR_SHIFT  = 11;
  localparam int SIX_W      = 10;

  // filter reset value: 1 V in counts, scaled by the fraction bits
  localparam int ONE_VOLT_COUNTS = (10 << ADC_BITS) / 33;
  localparam logic [FILT_W-1:0] FILT_RESET = FILT_W'(ONE_VOLT_COUNTS << FILTER_FRACTION_BITS);

  // register reset values
  localparam logic [ADC_BITS-1:0]     PILOT_STEP_RST   = ADC_BITS'(895);
  localparam logic [ADC_BITS-1:0]     PILOT_WINDOW_RST = ADC_BITS'(597);
  localparam logic [ADC_BITS-1:0]     PROX_OPEN_RST    = ADC_BITS'(3599);
  localparam logic [ADC_BITS-1:0]     PROX_PRESSED_RST = ADC_BITS'(2234);
  localparam logic [ADC_BITS-1:0]     PROX_LATCHED_RST = ADC_BITS'(1117);
  localparam logic [ADC_BITS-1:0]     PROX_WINDOW_RST  = ADC_BITS'(621);
  localparam logic [CAPTURE_BITS-1:0] NOM_FREQ_RST     = CAPTURE_BITS'(1000);
  localparam logic [CAPTURE_BITS-1:0] FREQ_TOL_RST     = CAPTURE_BITS'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PILOT_STEP   = 3'd0,
    CFG_PILOT_WINDOW = 3'd1,
    CFG_PROX_OPEN    = 3'd2,
    CFG_PROX_PRESSED = 3'd3,
    CFG_PROX_LATCHED = 3'd4,
    CFG_PROX_WINDOW  = 3'd5,
    CFG_NOM_FREQ     = 3'd6,
    CFG_FREQ_TOL     = 3'd7
  } evpsr_cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_PROX    = 2'd0,
    CMD_CAPTURE = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_RELAY   = 2'd3
  } evpsr_cmd_t;

  typedef enum logic [2:0] {
    PIL_NONE     = 3'd0,
    PIL_STANDBY  = 3'd1,
    PIL_DETECTED = 3'd2,
    PIL_CHARGE   = 3'd3,
    PIL_VENT     = 3'd4
  } evpsr_pilot_t;

  typedef enum logic [1:0] {
    PROX_UNPLUGGED = 2'd0,
    PROX_PRESSED   = 2'd1,
    PROX_LATCHED   = 2'd2
  } evpsr_prox_t;

  typedef struct packed {
    evpsr_cmd_t              command;
    logic [CAPTURE_BITS-1:0] period_us;
    logic [CAPTURE_BITS-1:0] high_us;
    logic [ADC_BITS-1:0]     sample;
    logic                    vent_request;
  } evpsr_in_t;

  typedef struct packed {
    evpsr_pilot_t      pilot_state;
    evpsr_prox_t       prox_state;
    logic [2:0]        relays;
    logic [FREQ_W-1:0] frequency_hz;
    logic [DUTY_W-1:0] duty_percent;
    logic [CUR_W-1:0]  charge_current_a;
  } evpsr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROX,
    ST_MEAS,
    ST_FDIV,
    ST_DDIV,
    ST_FSUM,
    ST_FMUL,
    ST_FWR,
    ST_CLASS,
    ST_RESULT
  } evpsr_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic prox_upd;
    logic meas_clr;
    logic p100_ld;
    logic div_start;
    logic div_sel_duty;
    logic freq_ld;
    logic duty_ld;
    logic duty_clr;
    logic filt_sum;
    logic filt_mul;
    logic filt_wr;
    logic class_ld;
    logic out_ld;
  } evpsr_dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    evpsr_cmd_t cmd;
    logic       latched;
    logic       period_zero;
    logic       p100_zero;
    logic       div_done;
  } evpsr_dp_sts_t;

  // c - w <= v <= c + w without wrap
  function automatic logic near_level(input logic [CMP_W-1:0] v,
                                      input logic [CMP_W-1:0] c,
                                      input logic [CMP_W-1:0] w);
    logic [CMP_W-1:0] vw;
    logic [CMP_W-1:0] cw;
    vw = v + w;
    cw = c + w;
    return (vw >= c) && (v <= cw);
  endfunction

endpackage

// ----- rtl/evpsr_div.sv -----
// evpsr_div: restoring divider, one quotient bit per cycle
// depends on evpsr_pkg for widths

module evpsr_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [evpsr_pkg::FREQ_W-1:0]       dividend,
  input  logic [evpsr_pkg::CAPTURE_BITS-1:0] divisor,
  output logic                              done,
  output logic [evpsr_pkg::FREQ_W-1:0]       quotient
);

  localparam int QW    = evpsr_pkg::FREQ_W;
  localparam int RW    = evpsr_pkg::CAPTURE_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [RW-1:0]    rem_r;
  logic [QW-1:0]    quo_r;
  logic [RW-1:0]    dvs_r;

  logic [RW:0]      trial;
  logic [RW:0]      diff;
  logic             ge;

  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[RW-1:0] : trial[RW-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/evpsr_dp.sv -----
// evpsr_dp: datapath with registers, state, filter, classifiers and result register
// depends on evpsr_pkg and evpsr_div

module evpsr_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  evpsr_pkg::evpsr_in_t             in_data,
  input  logic                             cfg_we,
  input  logic [evpsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evpsr_pkg::CFG_W-1:0]      cfg_wdata,
  input  evpsr_pkg::evpsr_dp_cmd_t         cmd,
  output evpsr_pkg::evpsr_dp_sts_t         sts,
  output evpsr_pkg::evpsr_out_t            out_data
);

  localparam int AW  = evpsr_pkg::ADC_BITS;
  localparam int CW  = evpsr_pkg::CAPTURE_BITS;
  localparam int FW  = evpsr_pkg::FILT_W;
  localparam int QW  = evpsr_pkg::FREQ_W;
  localparam int DW  = evpsr_pkg::DUTY_W;
  localparam int UW  = evpsr_pkg::CUR_W;
  localparam int MW  = evpsr_pkg::CMP_W;
  localparam int FB  = evpsr_pkg::FILTER_FRACTION_BITS;
  localparam int SW  = AW + 3;
  localparam int PMW = CW + evpsr_pkg::P100_MUL_W;
  localparam int TMW = evpsr_pkg::ACC_W + evpsr_pkg::TEN_MUL_W;
  localparam int CMW = evpsr_pkg::SIX_W + 8;

  // configuration
  logic [AW-1:0] pilot_step_r, pilot_window_r;
  logic [AW-1:0] prox_open_r, prox_pressed_r, prox_latched_r, prox_window_r;
  logic [CW-1:0] nom_freq_r, freq_tol_r;

  // captured item
  evpsr_pkg::evpsr_cmd_t cmd_r;
  logic [CW-1:0]         period_r, high_r;
  logic [AW-1:0]         sample_r;
  logic                  vent_r;

  // block state
  logic [AW-1:0]               prox_level_r;
  logic [FW-1:0]               filt_r;
  logic [QW-1:0]               freq_r;
  logic [DW-1:0]               duty_r;
  logic [UW-1:0]               cur_r;
  logic [2:0]                  relay_r;
  evpsr_pkg::evpsr_prox_t      prox_state_r;
  evpsr_pkg::evpsr_pilot_t     pilot_state_r;

  // work registers
  logic [evpsr_pkg::P100_W-1:0] p100_r;
  logic [evpsr_pkg::ACC_W-1:0]  acc_r;
  logic [TMW-1:0]               prod_r;
  evpsr_pkg::evpsr_out_t        out_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pilot_step_r   <= evpsr_pkg::PILOT_STEP_RST;
      pilot_window_r <= evpsr_pkg::PILOT_WINDOW_RST;
      prox_open_r    <= evpsr_pkg::PROX_OPEN_RST;
      prox_pressed_r <= evpsr_pkg::PROX_PRESSED_RST;
      prox_latched_r <= evpsr_pkg::PROX_LATCHED_RST;
      prox_window_r  <= evpsr_pkg::PROX_WINDOW_RST;
      nom_freq_r     <= evpsr_pkg::NOM_FREQ_RST;
      freq_tol_r     <= evpsr_pkg::FREQ_TOL_RST;
    end else if (cfg_we) begin
      unique case (evpsr_pkg::evpsr_cfg_idx_t'(cfg_index))
        evpsr_pkg::CFG_PILOT_STEP:   pilot_step_r   <= cfg_wdata[AW-1:0];
        evpsr_pkg::CFG_PILOT_WINDOW: pilot_window_r <= cfg_wdata[AW-1:0];
        evpsr_pkg::CFG_PROX_OPEN:    prox_open_r    <= cfg_wdata[AW-1:0];
        evpsr_pkg::CFG_PROX_PRESSED: prox_pressed_r <= cfg_wdata[AW-1:0];
        evpsr_pkg::CFG_PROX_LATCHED: prox_latched_r <= cfg_wdata[AW-1:0];
        evpsr_pkg::CFG_PROX_WINDOW:  prox_window_r  <= cfg_wdata[AW-1:0];
        evpsr_pkg::CFG_NOM_FREQ:     nom_freq_r     <= cfg_wdata[CW-1:0];
        evpsr_pkg::CFG_FREQ_TOL:     freq_tol_r     <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // proximity classification from the level after this item
  logic [AW-1:0]          prox_src;
  evpsr_pkg::evpsr_prox_t prox_cls;

  assign prox_src = (cmd_r == evpsr_pkg::CMD_PROX) ? sample_r : prox_level_r;

  always_comb begin
    if (evpsr_pkg::near_level(MW'(prox_src), MW'(prox_open_r), MW'(prox_window_r))) begin
      prox_cls = evpsr_pkg::PROX_UNPLUGGED;
    end else if (evpsr_pkg::near_level(MW'(prox_src), MW'(prox_pressed_r),
                                       MW'(prox_window_r))) begin
      prox_cls = evpsr_pkg::PROX_PRESSED;
    end else if (evpsr_pkg::near_level(MW'(prox_src), MW'(prox_latched_r),
                                       MW'(prox_window_r))) begin
      prox_cls = evpsr_pkg::PROX_LATCHED;
    end else begin
      prox_cls = evpsr_pkg::PROX_UNPLUGGED;
    end
  end

  // divider, shared by frequency and duty
  logic [QW-1:0] div_dvd;
  logic [CW-1:0] div_dvs;
  logic          div_done;
  logic [QW-1:0] div_q;

  assign div_dvd = cmd.div_sel_duty ? QW'(high_r) : QW'(evpsr_pkg::FREQ_NUM);
  assign div_dvs = cmd.div_sel_duty ? CW'(p100_r) : period_r;

  evpsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // period / 100
  logic [PMW-1:0] p100_prod;
  assign p100_prod = PMW'(period_r) * PMW'(evpsr_pkg::P100_MUL);

  // duty saturation and current
  logic [DW-1:0]                   duty_sat;
  logic [evpsr_pkg::SIX_W-1:0]     six_duty;
  logic [CMW-1:0]                  cur_prod;

  assign duty_sat = (div_q > QW'(evpsr_pkg::DUTY_MAX)) ? DW'(evpsr_pkg::DUTY_MAX)
                                                        : div_q[DW-1:0];
  assign six_duty = evpsr_pkg::SIX_W'(duty_sat) * evpsr_pkg::SIX_W'(6);
  assign cur_prod = CMW'(six_duty) * CMW'(evpsr_pkg::CUR_MUL);

  // filter sum: sample scaled up plus nine times old value
  logic [evpsr_pkg::ACC_W-1:0] filt_acc;
  assign filt_acc = (evpsr_pkg::ACC_W'(sample_r) << FB)
                  + (evpsr_pkg::ACC_W'(filt_r) << 3)
                  + evpsr_pkg::ACC_W'(filt_r);

  // pilot classification against 0, 3, 6, 9 and 12 volt levels
  logic [SW-1:0]           step1, step2, step3, step4;
  logic [MW-1:0]           pwin;
  logic                    n0, n1, n2, n3, n4, fz, fok;
  evpsr_pkg::evpsr_pilot_t pil_cls;

  assign step1 = SW'(pilot_step_r);
  assign step2 = SW'(pilot_step_r) << 1;
  assign step3 = (SW'(pilot_step_r) << 1) + SW'(pilot_step_r);
  assign step4 = SW'(pilot_step_r) << 2;
  assign pwin  = MW'(pilot_window_r) << FB;

  assign n0  = evpsr_pkg::near_level(MW'(filt_r), '0, pwin);
  assign n1  = evpsr_pkg::near_level(MW'(filt_r), MW'(step1) << FB, pwin);
  assign n2  = evpsr_pkg::near_level(MW'(filt_r), MW'(step2) << FB, pwin);
  assign n3  = evpsr_pkg::near_level(MW'(filt_r), MW'(step3) << FB, pwin);
  assign n4  = evpsr_pkg::near_level(MW'(filt_r), MW'(step4) << FB, pwin);
  assign fz  = (freq_r == '0);
  assign fok = evpsr_pkg::near_level(MW'(freq_r), MW'(nom_freq_r), MW'(freq_tol_r));

  always_comb begin
    if (n0) begin
      pil_cls = evpsr_pkg::PIL_NONE;
    end else if ((n4 && fz) || (n3 && fz)) begin
      pil_cls = evpsr_pkg::PIL_STANDBY;
    end else if (n3 && fok) begin
      pil_cls = evpsr_pkg::PIL_DETECTED;
    end else if (n2 && fok) begin
      pil_cls = evpsr_pkg::PIL_CHARGE;
    end else if (n1 && fok) begin
      pil_cls = evpsr_pkg::PIL_VENT;
    end else begin
      pil_cls = evpsr_pkg::PIL_NONE;
    end
  end

  // relay update
  logic [2:0] relay_nxt;

  always_comb begin
    relay_nxt = relay_r;
    if (cmd_r == evpsr_pkg::CMD_RELAY) begin
      if (prox_state_r != evpsr_pkg::PROX_LATCHED) begin
        relay_nxt = 3'b000;
      end else begin
        case (pilot_state_r)
          evpsr_pkg::PIL_STANDBY:  relay_nxt = relay_r | 3'b001;
          evpsr_pkg::PIL_DETECTED: relay_nxt = relay_r | 3'b010;
          evpsr_pkg::PIL_CHARGE:   relay_nxt = vent_r ? (relay_r | 3'b100)
                                                      : (relay_r & 3'b011);
          evpsr_pkg::PIL_VENT:     relay_nxt = vent_r ? relay_r : (relay_r & 3'b011);
          default:                 relay_nxt = 3'b000;
        endcase
      end
    end
  end

  // control-visible state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prox_level_r  <= '0;
      filt_r        <= evpsr_pkg::FILT_RESET;
      freq_r        <= '0;
      duty_r        <= '0;
      cur_r         <= '0;
      relay_r       <= '0;
      prox_state_r  <= evpsr_pkg::PROX_UNPLUGGED;
      pilot_state_r <= evpsr_pkg::PIL_NONE;
    end else begin
      if (cmd.prox_upd) begin
        if (cmd_r == evpsr_pkg::CMD_PROX) begin
          prox_level_r <= sample_r;
        end
        prox_state_r <= prox_cls;
      end
      if (cmd.meas_clr) begin
        freq_r <= '0;
        duty_r <= '0;
        cur_r  <= '0;
      end
      if (cmd.freq_ld) begin
        freq_r <= div_q;
      end
      if (cmd.duty_clr) begin
        duty_r <= '0;
        cur_r  <= '0;
      end
      if (cmd.duty_ld) begin
        duty_r <= duty_sat;
        cur_r  <= cur_prod[evpsr_pkg::CUR_SHIFT +: UW];
      end
      if (cmd.filt_wr) begin
        filt_r <= prod_r[evpsr_pkg::TEN_SHIFT +: FW];
      end
      if (cmd.class_ld) begin
        pilot_state_r <= pil_cls;
      end
      if (cmd.out_ld) begin
        relay_r <= relay_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= in_data.command;
      period_r <= in_data.period_us;
      high_r   <= in_data.high_us;
      sample_r <= in_data.sample;
      vent_r   <= in_data.vent_request;
    end
    if (cmd.p100_ld) begin
      p100_r <= p100_prod[evpsr_pkg::P100_SHIFT +: evpsr_pkg::P100_W];
    end
    if (cmd.filt_sum) begin
      acc_r <= filt_acc;
    end
    if (cmd.filt_mul) begin
      prod_r <= TMW'(acc_r) * TMW'(evpsr_pkg::TEN_MUL);
    end
    if (cmd.out_ld) begin
      out_r.pilot_state      <= pilot_state_r;
      out_r.prox_state       <= prox_state_r;
      out_r.relays           <= relay_nxt;
      out_r.frequency_hz     <= freq_r;
      out_r.duty_percent     <= duty_r;
      out_r.charge_current_a <= cur_r;
    end
  end

  assign sts.cmd         = cmd_r;
  assign sts.latched     = (prox_state_r == evpsr_pkg::PROX_LATCHED);
  assign sts.period_zero = (period_r == '0);
  assign sts.p100_zero   = (p100_r == '0);
  assign sts.div_done    = div_done;

  assign out_data = out_r;

endmodule

// ----- rtl/evpsr_ctrl.sv -----
// evpsr_ctrl: sequencer for one item at a time plus result handshake
// depends on evpsr_pkg

module evpsr_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  evpsr_pkg::evpsr_dp_sts_t sts,
  output evpsr_pkg::evpsr_dp_cmd_t cmd
);

  evpsr_pkg::evpsr_state_t state_r, state_nxt;
  logic                    out_valid_r;
  logic                    slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= evpsr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      evpsr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = evpsr_pkg::ST_PROX;
      end
      evpsr_pkg::ST_PROX: state_nxt = evpsr_pkg::ST_MEAS;
      evpsr_pkg::ST_MEAS: begin
        if (!sts.latched) begin
          state_nxt = evpsr_pkg::ST_CLASS;
        end else begin
          case (sts.cmd)
            evpsr_pkg::CMD_CAPTURE: state_nxt = sts.period_zero ? evpsr_pkg::ST_FSUM
                                                                : evpsr_pkg::ST_FDIV;
            evpsr_pkg::CMD_TIMEOUT: state_nxt = evpsr_pkg::ST_FSUM;
            default:                state_nxt = evpsr_pkg::ST_CLASS;
          endcase
        end
      end
      evpsr_pkg::ST_FDIV: begin
        if (sts.div_done) begin
          state_nxt = sts.p100_zero ? evpsr_pkg::ST_FSUM : evpsr_pkg::ST_DDIV;
        end
      end
      evpsr_pkg::ST_DDIV: begin
        if (sts.div_done) state_nxt = evpsr_pkg::ST_FSUM;
      end
      evpsr_pkg::ST_FSUM:  state_nxt = evpsr_pkg::ST_FMUL;
      evpsr_pkg::ST_FMUL:  state_nxt = evpsr_pkg::ST_FWR;
      evpsr_pkg::ST_FWR:   state_nxt = evpsr_pkg::ST_CLASS;
      evpsr_pkg::ST_CLASS: state_nxt = evpsr_pkg::ST_RESULT;
      evpsr_pkg::ST_RESULT: begin
        if (slot_free) state_nxt = evpsr_pkg::ST_IDLE;
      end
      default: state_nxt = evpsr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      evpsr_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      evpsr_pkg::ST_PROX: cmd.prox_upd = 1'b1;
      evpsr_pkg::ST_MEAS: begin
        if (!sts.latched) begin
          cmd.meas_clr = 1'b1;
        end else begin
          case (sts.cmd)
            evpsr_pkg::CMD_CAPTURE: begin
              if (sts.period_zero) begin
                cmd.meas_clr = 1'b1;
              end else begin
                cmd.div_start = 1'b1;
                cmd.p100_ld   = 1'b1;
              end
            end
            evpsr_pkg::CMD_TIMEOUT: cmd.meas_clr = 1'b1;
            default: ;
          endcase
        end
      end
      evpsr_pkg::ST_FDIV: begin
        if (sts.div_done) begin
          cmd.freq_ld = 1'b1;
          if (sts.p100_zero) begin
            cmd.duty_clr = 1'b1;
          end else begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_duty = 1'b1;
          end
        end
      end
      evpsr_pkg::ST_DDIV: begin
        cmd.div_sel_duty = 1'b1;
        cmd.duty_ld      = sts.div_done;
      end
      evpsr_pkg::ST_FSUM:   cmd.filt_sum = 1'b1;
      evpsr_pkg::ST_FMUL:   cmd.filt_mul = 1'b1;
      evpsr_pkg::ST_FWR:    cmd.filt_wr  = 1'b1;
      evpsr_pkg::ST_CLASS:  cmd.class_ld = 1'b1;
      evpsr_pkg::ST_RESULT: cmd.out_ld   = slot_free;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/ev_pilot_state_relay_controller.sv -----
// ev_pilot_state_relay_controller: top level of the vehicle side control pilot block
// instantiates evpsr_ctrl and evpsr_dp; types and constants from evpsr_pkg
//
//  port group  direction  handshake              payload
//  in_*        input      in_valid / in_ready    evpsr_in_t  (command, capture, adc sample)
//  out_*       output     out_valid / out_ready  evpsr_out_t (states, relays, measurements)
//  cfg_*       input      cfg_we, no wait        cfg_index selects one of eight registers
//
// one item at a time; prox samples, relay updates and unlatched items skip the filter
// and divider, a timeout or zero-period capture runs the filter, a capture with a period
// under 100 us adds a frequency pass through the shared divider and a full capture a
// second pass for duty; the result sits in an output register, so the next item is
// taken while it waits; a stalled output only holds the sequencer in its final step
// reset is synchronous, active low and restores config, state and handshake registers

module ev_pilot_state_relay_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  evpsr_pkg::evpsr_in_t            in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output evpsr_pkg::evpsr_out_t           out_data,
  input  logic                            cfg_we,
  input  logic [evpsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [evpsr_pkg::CFG_W-1:0]     cfg_wdata
);

  // command and status between sequencer and datapath
  evpsr_pkg::evpsr_dp_cmd_t dp_cmd;
  evpsr_pkg::evpsr_dp_sts_t dp_sts;

  // sequencer: accept, walk through measure / filter / classify, load result
  evpsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // datapath: config registers, state, divider, filter and classifiers
  evpsr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_data  (out_data)
  );

endmodule
